FILE: rtl/core/lsps_pkg.sv
// Shared types, constants and the sensor weight table for the line sensor
// PD steering block. No dependencies.
package lsps_pkg;

  // fixed field widths
  localparam int SENSOR_COUNT = 12;
  localparam int TIME_W       = 32;
  localparam int GAIN_W       = 14;
  localparam int INTV_W       = 10;
  localparam int MAXC_W       = 14;
  localparam int LLIM_W       = 8;
  localparam int SPIN_W       = 14;
  localparam int OUT_W        = 15;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 14;
  localparam int WEIGHT_W     = 6;
  localparam int SUM_W        = 8;
  localparam int COUNT_W      = 4;
  localparam int STEP_W       = 4;
  localparam int DVS_W        = 7;

  // default fraction bits of the position
  localparam int FRAC_BITS_DEF = 8;

  // bits of the scaled PD numerator left after dropping the fraction
  localparam int TERM_MAG_W = 21;

  // scale divisor of the PD term after the fraction shift
  localparam logic [DVS_W-1:0] PCT_DIVISOR = 7'd100;

  // register reset values
  localparam logic [GAIN_W-1:0] KP_RST   = 14'd0;
  localparam logic [GAIN_W-1:0] KD_RST   = 14'd0;
  localparam logic [INTV_W-1:0] INTV_RST = 10'd10;
  localparam logic [MAXC_W-1:0] MAXC_RST = 14'd1000;
  localparam logic [LLIM_W-1:0] LLIM_RST = 8'd3;
  localparam logic [SPIN_W-1:0] SPIN_RST = 14'd400;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_KP   = 3'd0,
    CFG_KD   = 3'd1,
    CFG_INTV = 3'd2,
    CFG_MAXC = 3'd3,
    CFG_LLIM = 3'd4,
    CFG_SPIN = 3'd5
  } cfg_idx_t;

  // control sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SETUP,
    ST_DIVP,
    ST_MULSET,
    ST_MUL,
    ST_DIVSET,
    ST_DIVT,
    ST_FINISH
  } state_t;

  // serial divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // weight of each sensor, leftmost first
  function automatic logic signed [WEIGHT_W-1:0] sensor_weight(input logic [STEP_W-1:0] idx);
    logic signed [WEIGHT_W-1:0] w;
    case (idx)
      4'd0:    w = -6'sd24;
      4'd1:    w = -6'sd18;
      4'd2:    w = -6'sd14;
      4'd3:    w = -6'sd11;
      4'd4:    w = -6'sd6;
      4'd5:    w = -6'sd2;
      4'd6:    w = 6'sd2;
      4'd7:    w = 6'sd6;
      4'd8:    w = 6'sd11;
      4'd9:    w = 6'sd14;
      4'd10:   w = 6'sd18;
      4'd11:   w = 6'sd24;
      default: w = 6'sd0;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/core/line_sensor_pd_steering_top.sv
// Line sensor PD steering block: update gating, weighted centroid, PD term.
// Depends on lsps_pkg and the serial divider lsps_serdiv.
//
// One item is in work at a time and one result leaves for every item taken.
// A sample that comes before the update interval has passed skips the update
// and returns the held correction through the finish state; an update with no
// active sensor skips both divides and the multiplier. In a full update the
// sensors are scanned one per cycle, the position and the final scaling each
// run through the shared bit-serial divider, DIV_W bits wide, the larger of
// FRAC_BITS+7 and 21, and the gains are applied by a shift-add multiplier one
// gain bit per cycle.
// A new item may be taken while the previous result waits on the output.
module line_sensor_pd_steering_top #(
  parameter int FRAC_BITS = lsps_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lsps_pkg::SENSOR_COUNT-1:0]   in_sensor_bits,
  input  logic [lsps_pkg::TIME_W-1:0]         in_now_ms,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lsps_pkg::OUT_W-1:0]   out_steer_correction,
  // configuration port
  input  logic                                cfg_we,
  input  logic [lsps_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [lsps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int POS_W = FRAC_BITS + 6;
  localparam int DEL_W = FRAC_BITS + 7;
  localparam int NUM_W = FRAC_BITS + 22;
  localparam int DIV_W = (FRAC_BITS + 7 > lsps_pkg::TERM_MAG_W) ?
                         FRAC_BITS + 7 : lsps_pkg::TERM_MAG_W;
  localparam int GW    = lsps_pkg::GAIN_W;
  localparam int OW    = lsps_pkg::OUT_W;

  // configuration registers
  logic [GW-1:0]                  kp_r, kd_r;
  logic [lsps_pkg::INTV_W-1:0]    intv_r;
  logic [lsps_pkg::MAXC_W-1:0]    maxc_r;
  logic [lsps_pkg::LLIM_W-1:0]    llim_r;
  logic [lsps_pkg::SPIN_W-1:0]    spin_r;

  // control state
  lsps_pkg::state_t               state_r, state_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [lsps_pkg::TIME_W-1:0]    last_ms_r, last_ms_nxt;
  logic signed [OW-1:0]           held_r, held_nxt;
  logic signed [POS_W-1:0]        prev_pos_r, prev_pos_nxt;
  logic                           last_neg_r, last_neg_nxt;
  logic [lsps_pkg::LLIM_W-1:0]    lost_r, lost_nxt;
  logic                           seen_r, seen_nxt;

  // datapath registers
  logic signed [OW-1:0]                 out_steer_r, out_steer_nxt;
  logic [lsps_pkg::SENSOR_COUNT-1:0]    bits_r, bits_nxt;
  logic [lsps_pkg::STEP_W-1:0]          cnt_r, cnt_nxt;
  logic signed [lsps_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [lsps_pkg::COUNT_W-1:0]         count_r, count_nxt;
  logic                                 sum_neg_r, sum_neg_nxt;
  logic signed [POS_W-1:0]              pos_r, pos_nxt;
  logic signed [NUM_W-1:0]              mpos_r, mpos_nxt;
  logic signed [NUM_W-1:0]              mdel_r, mdel_nxt;
  logic signed [NUM_W-1:0]              acc_r, acc_nxt;
  logic [GW-1:0]                        kp_sh_r, kp_sh_nxt;
  logic [GW-1:0]                        kd_sh_r, kd_sh_nxt;
  logic                                 num_neg_r, num_neg_nxt;
  logic signed [OW-1:0]                 res_r, res_nxt;

  // divider hookup
  logic                           div_start;
  logic [DIV_W-1:0]               div_dividend;
  logic [lsps_pkg::DVS_W-1:0]     div_divisor;
  lsps_pkg::div_sts_t             div_sts;
  logic [DIV_W-1:0]               div_quo;

  // combinational helpers
  logic [lsps_pkg::TIME_W-1:0]          time_diff;
  logic                                 too_early;
  logic signed [lsps_pkg::WEIGHT_W-1:0] weight;
  logic [lsps_pkg::SUM_W-1:0]           abs_sum;
  logic [POS_W-1:0]                     pos_mag;
  logic signed [DEL_W-1:0]              delta;
  logic [NUM_W-1:0]                     acc_mag;
  logic [NUM_W-1:0]                     acc_shift;
  logic [lsps_pkg::LLIM_W-1:0]          lost_inc;
  logic                                 over_max;
  logic [lsps_pkg::MAXC_W-1:0]          q_clamp;
  logic signed [OW-1:0]                 q_ext;

  lsps_serdiv #(
    .W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= lsps_pkg::KP_RST;
      kd_r   <= lsps_pkg::KD_RST;
      intv_r <= lsps_pkg::INTV_RST;
      maxc_r <= lsps_pkg::MAXC_RST;
      llim_r <= lsps_pkg::LLIM_RST;
      spin_r <= lsps_pkg::SPIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lsps_pkg::CFG_KP:   kp_r   <= cfg_wdata[GW-1:0];
        lsps_pkg::CFG_KD:   kd_r   <= cfg_wdata[GW-1:0];
        lsps_pkg::CFG_INTV: intv_r <= cfg_wdata[lsps_pkg::INTV_W-1:0];
        lsps_pkg::CFG_MAXC: maxc_r <= cfg_wdata[lsps_pkg::MAXC_W-1:0];
        lsps_pkg::CFG_LLIM: llim_r <= cfg_wdata[lsps_pkg::LLIM_W-1:0];
        lsps_pkg::CFG_SPIN: spin_r <= cfg_wdata[lsps_pkg::SPIN_W-1:0];
        default: ;
      endcase
    end
  end

  // helper arithmetic
  assign time_diff = in_now_ms - last_ms_r;
  assign too_early = (time_diff < lsps_pkg::TIME_W'(intv_r));
  assign weight    = lsps_pkg::sensor_weight(cnt_r);
  assign abs_sum   = sum_r[lsps_pkg::SUM_W-1] ? (-sum_r) : sum_r;
  assign pos_mag   = {1'b0, div_quo[POS_W-2:0]};
  assign delta     = {pos_r[POS_W-1], pos_r} - {prev_pos_r[POS_W-1], prev_pos_r};
  assign acc_mag   = acc_r[NUM_W-1] ? (-acc_r) : acc_r;
  assign acc_shift = acc_mag >> FRAC_BITS;
  assign lost_inc  = (lost_r == '1) ? lost_r : lost_r + 1'b1;
  assign over_max  = (div_quo > DIV_W'(maxc_r));
  assign q_clamp   = over_max ? maxc_r : div_quo[lsps_pkg::MAXC_W-1:0];
  assign q_ext     = {1'b0, q_clamp};

  // sequencer: next state and datapath
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    last_ms_nxt   = last_ms_r;
    held_nxt      = held_r;
    prev_pos_nxt  = prev_pos_r;
    last_neg_nxt  = last_neg_r;
    lost_nxt      = lost_r;
    seen_nxt      = seen_r;
    out_steer_nxt = out_steer_r;
    bits_nxt      = bits_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    sum_neg_nxt   = sum_neg_r;
    pos_nxt       = pos_r;
    mpos_nxt      = mpos_r;
    mdel_nxt      = mdel_r;
    acc_nxt       = acc_r;
    kp_sh_nxt     = kp_sh_r;
    kd_sh_nxt     = kd_sh_r;
    num_neg_nxt   = num_neg_r;
    res_nxt       = res_r;
    div_start     = 1'b0;
    div_dividend  = '0;
    div_divisor   = '0;

    // result taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      lsps_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (too_early) begin
            res_nxt   = held_r;
            state_nxt = lsps_pkg::ST_FINISH;
          end else begin
            last_ms_nxt = in_now_ms;
            bits_nxt    = in_sensor_bits;
            cnt_nxt     = '0;
            sum_nxt     = '0;
            count_nxt   = '0;
            state_nxt   = lsps_pkg::ST_SCAN;
          end
        end
      end

      // one sensor per cycle
      lsps_pkg::ST_SCAN: begin
        if (bits_r[0]) begin
          sum_nxt   = sum_r + {{(lsps_pkg::SUM_W - lsps_pkg::WEIGHT_W){weight[
                      lsps_pkg::WEIGHT_W-1]}}, weight};
          count_nxt = count_r + 1'b1;
        end
        bits_nxt = bits_r >> 1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == lsps_pkg::STEP_W'(lsps_pkg::SENSOR_COUNT - 1)) begin
          state_nxt = lsps_pkg::ST_SETUP;
        end
      end

      // lost line handling or start of the position divide
      lsps_pkg::ST_SETUP: begin
        if (count_r == '0) begin
          if (!seen_r) begin
            res_nxt = '0;
          end else begin
            lost_nxt = lost_inc;
            if (lost_inc > llim_r) begin
              held_nxt = last_neg_r ? $signed({1'b0, spin_r}) : -$signed({1'b0, spin_r});
              res_nxt  = held_nxt;
            end else begin
              res_nxt = held_r;
            end
          end
          state_nxt = lsps_pkg::ST_FINISH;
        end else begin
          lost_nxt     = '0;
          seen_nxt     = 1'b1;
          last_neg_nxt = sum_r[lsps_pkg::SUM_W-1];
          sum_neg_nxt  = sum_r[lsps_pkg::SUM_W-1];
          div_start    = 1'b1;
          div_dividend = DIV_W'(abs_sum) << FRAC_BITS;
          div_divisor  = lsps_pkg::DVS_W'(count_r);
          state_nxt    = lsps_pkg::ST_DIVP;
        end
      end

      lsps_pkg::ST_DIVP: begin
        if (div_sts.done) begin
          pos_nxt   = sum_neg_r ? $signed(-pos_mag) : $signed(pos_mag);
          state_nxt = lsps_pkg::ST_MULSET;
        end
      end

      // load the multiplicands
      lsps_pkg::ST_MULSET: begin
        mpos_nxt  = {{(NUM_W - POS_W){pos_r[POS_W-1]}}, pos_r};
        mdel_nxt  = {{(NUM_W - DEL_W){delta[DEL_W-1]}}, delta};
        acc_nxt   = '0;
        kp_sh_nxt = kp_r;
        kd_sh_nxt = kd_r;
        cnt_nxt   = '0;
        state_nxt = lsps_pkg::ST_MUL;
      end

      // shift-add, one bit of each gain per cycle
      lsps_pkg::ST_MUL: begin
        acc_nxt   = acc_r + (kp_sh_r[0] ? mpos_r : '0) + (kd_sh_r[0] ? mdel_r : '0);
        mpos_nxt  = mpos_r <<< 1;
        mdel_nxt  = mdel_r <<< 1;
        kp_sh_nxt = kp_sh_r >> 1;
        kd_sh_nxt = kd_sh_r >> 1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == lsps_pkg::STEP_W'(GW - 1)) begin
          state_nxt = lsps_pkg::ST_DIVSET;
        end
      end

      // drop the fraction and divide by the percent scale
      lsps_pkg::ST_DIVSET: begin
        num_neg_nxt  = acc_r[NUM_W-1];
        div_start    = 1'b1;
        div_dividend = DIV_W'(acc_shift);
        div_divisor  = lsps_pkg::PCT_DIVISOR;
        state_nxt    = lsps_pkg::ST_DIVT;
      end

      // negate and clamp
      lsps_pkg::ST_DIVT: begin
        if (div_sts.done) begin
          res_nxt      = num_neg_r ? q_ext : -q_ext;
          held_nxt     = res_nxt;
          prev_pos_nxt = pos_r;
          state_nxt    = lsps_pkg::ST_FINISH;
        end
      end

      // hand the result to the output register
      lsps_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_steer_nxt = res_r;
          state_nxt     = lsps_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lsps_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lsps_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      last_ms_r   <= '0;
      held_r      <= '0;
      prev_pos_r  <= '0;
      last_neg_r  <= 1'b0;
      lost_r      <= '0;
      seen_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_ms_r   <= last_ms_nxt;
      held_r      <= held_nxt;
      prev_pos_r  <= prev_pos_nxt;
      last_neg_r  <= last_neg_nxt;
      lost_r      <= lost_nxt;
      seen_r      <= seen_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    out_steer_r <= out_steer_nxt;
    bits_r      <= bits_nxt;
    cnt_r       <= cnt_nxt;
    sum_r       <= sum_nxt;
    count_r     <= count_nxt;
    sum_neg_r   <= sum_neg_nxt;
    pos_r       <= pos_nxt;
    mpos_r      <= mpos_nxt;
    mdel_r      <= mdel_nxt;
    acc_r       <= acc_nxt;
    kp_sh_r     <= kp_sh_nxt;
    kd_sh_r     <= kd_sh_nxt;
    num_neg_r   <= num_neg_nxt;
    res_r       <= res_nxt;
  end

  assign in_ready             = (state_r == lsps_pkg::ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_steer_correction = out_steer_r;

  // an accepted item always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != lsps_pkg::ST_IDLE)
    else $error("accepted item did not start work");

  // the divider only runs during the two divide phases
  a_div_phase: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.busy |-> (state_r == lsps_pkg::ST_DIVP || state_r == lsps_pkg::ST_DIVT))
    else $error("divider busy outside a divide phase");

  // a lost count needs a line that was seen
  a_lost_seen: assert property (@(posedge clk) disable iff (!rst_n)
    lost_r != '0 |-> seen_r)
    else $error("lost count without line seen");

  // a finished result is never dropped while the output is stalled
  a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lsps_pkg::ST_FINISH && out_valid_r && !out_ready |=>
      state_r == lsps_pkg::ST_FINISH)
    else $error("result left finish while output stalled");

endmodule

FILE: rtl/core/lsps_serdiv.sv
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// Depends on lsps_pkg for the divisor width and the status struct.
module lsps_serdiv #(
  parameter int W = 21
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [W-1:0]              dividend,
  input  logic [lsps_pkg::DVS_W-1:0] divisor,
  output lsps_pkg::div_sts_t        sts,
  output logic [W-1:0]              quotient
);

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0]                cnt_r;
  logic                         done_r;
  logic [lsps_pkg::DVS_W-1:0]   rem_r;
  logic [lsps_pkg::DVS_W-1:0]   dvs_r;
  logic [W-1:0]                 quo_r;
  logic [lsps_pkg::DVS_W:0]     trial;
  logic [lsps_pkg::DVS_W:0]     diff;
  logic                         ge;

  // one trial subtract per cycle
  assign trial = {rem_r, quo_r[W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CW'(W);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == CW'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  // remainder and quotient shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? diff[lsps_pkg::DVS_W-1:0] : trial[lsps_pkg::DVS_W-1:0];
      quo_r <= {quo_r[W-2:0], ge};
    end
  end

  assign sts.busy = (cnt_r != '0);
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule
